>>> design/isu_pkg.sv
package isu_pkg;

    // Bound width is fixed by the word format on both channels.
    localparam int BOUND_WIDTH = 16;

    // Default number of stored ranges.
    localparam int TABLE_DEPTH_DEF = 16;

    typedef logic [BOUND_WIDTH-1:0] bound_t;

    // Operation codes carried in the command word.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Command word.
    typedef struct packed {
        logic   op;
        bound_t range_high;
        bound_t range_low;
    } cmd_word_t;

    // Result word, one per stored range.
    typedef struct packed {
        bound_t entry_high;
        bound_t entry_low;
        logic   last;
        logic   empty_res;
        logic   rejected;
    } res_word_t;

    // One table entry as held in the banks.
    typedef struct packed {
        bound_t high;
        bound_t low;
    } range_t;

    // Operands of the shared compare unit.
    typedef struct packed {
        bound_t lt_a;
        bound_t lt_b;
        bound_t ovl_lo;
        bound_t ovl_hi;
        bound_t min_b;
    } cmp_op_t;

    // Results of the shared compare unit.
    typedef struct packed {
        logic   lt;
        logic   ovl;
        bound_t min_lo;
    } cmp_res_t;

endpackage

>>> design/isu_bank.sv
module isu_bank
    import isu_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  range_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output range_t        rd_data
);

    range_t mem [TABLE_DEPTH];
    range_t rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/isu_cmp.sv
module isu_cmp
    import isu_pkg::*;
(
    input  cmp_op_t  ops,
    output cmp_res_t res
);

    // Ordering compare: high bound check on accept, placement check while merging.
    assign res.lt = ops.lt_a < ops.lt_b;

    // Overlap test between the open range and the next one.
    assign res.ovl = ops.ovl_lo <= ops.ovl_hi;

    // Smaller of the two low bounds for a merged range.
    assign res.min_lo = (ops.min_b < ops.ovl_lo) ? ops.min_b : ops.ovl_lo;

endmodule

>>> design/isu_seq.sv
module isu_seq
    import isu_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  cmd_word_t     cmd,
    output logic          cmd_stall,
    input  range_t        rd_data,
    input  logic          out_ready,
    output logic          out_load,
    output res_word_t     out_word,
    output logic          bank_sel,
    output logic          wr_en,
    output logic          wr_bank,
    output logic [AW-1:0] wr_addr,
    output range_t        wr_data,
    output logic [AW-1:0] rd_addr
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MERGE  = 5'b00010,
        S_FLUSH  = 5'b00100,
        S_PRIME  = 5'b01000,
        S_STREAM = 5'b10000
    } state_t;

    state_t        state_reg,     state_next;
    logic [CW-1:0] count_reg,     count_next;
    logic [CW-1:0] rd_idx_reg,    rd_idx_next;
    logic [CW-1:0] wr_idx_reg,    wr_idx_next;
    logic          pend_reg,      pend_next;
    logic          acc_valid_reg, acc_valid_next;
    logic          rej_reg,       rej_next;
    logic          bank_sel_reg,  bank_sel_next;
    range_t        acc_reg,       acc_next;
    range_t        new_reg,       new_next;

    logic          have_entry;
    logic          take_new;
    logic          is_last;
    range_t        sel;
    cmp_op_t       cmp_ops;
    cmp_res_t      cmp_res;

    // Pick the next range of the sorted stream: the new range goes in front
    // of the first stored range with a strictly lower high bound.
    assign have_entry = rd_idx_reg < count_reg;
    assign take_new   = pend_reg && (!have_entry || cmp_res.lt);
    assign sel        = take_new ? new_reg : rd_data;
    assign is_last    = (rd_idx_reg + CW'(1)) == count_reg;

    // Operand steering for the shared compare unit.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            cmp_ops.lt_a = cmd.range_high;
            cmp_ops.lt_b = cmd.range_low;
        end
        else
        begin
            cmp_ops.lt_a = rd_data.high;
            cmp_ops.lt_b = new_reg.high;
        end
        cmp_ops.ovl_lo = acc_reg.low;
        cmp_ops.ovl_hi = sel.high;
        cmp_ops.min_b  = sel.low;
    end

    isu_cmp u_cmp (
        .ops (cmp_ops),
        .res (cmp_res)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        pend_next      = pend_reg;
        acc_valid_next = acc_valid_reg;
        rej_next       = rej_reg;
        bank_sel_next  = bank_sel_reg;
        acc_next       = acc_reg;
        new_next       = new_reg;
        wr_en          = 1'b0;
        out_load       = 1'b0;
        out_word       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    rd_idx_next = '0;
                    rej_next    = 1'b0;
                    if (cmd.op == OP_CLEAR)
                    begin
                        count_next = '0;
                        state_next = S_STREAM;
                    end
                    else if (cmp_res.lt || (count_reg >= CW'(TABLE_DEPTH)))
                    begin
                        rej_next   = 1'b1;
                        state_next = S_STREAM;
                    end
                    else
                    begin
                        new_next.high  = cmd.range_high;
                        new_next.low   = cmd.range_low;
                        pend_next      = 1'b1;
                        acc_valid_next = 1'b0;
                        wr_idx_next    = '0;
                        state_next     = S_MERGE;
                    end
                end
            end

            S_MERGE:
            begin
                if (!have_entry && !pend_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    if (take_new)
                    begin
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + CW'(1);
                    end

                    // Open, extend, or close and write out the current range.
                    if (!acc_valid_reg)
                    begin
                        acc_next       = sel;
                        acc_valid_next = 1'b1;
                    end
                    else if (cmp_res.ovl)
                    begin
                        acc_next.low = cmp_res.min_lo;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_idx_next = wr_idx_reg + CW'(1);
                        acc_next    = sel;
                    end
                end
            end

            S_FLUSH:
            begin
                wr_en         = 1'b1;
                count_next    = wr_idx_reg + CW'(1);
                bank_sel_next = ~bank_sel_reg;
                state_next    = S_PRIME;
            end

            S_PRIME:
            begin
                rd_idx_next = '0;
                state_next  = S_STREAM;
            end

            S_STREAM:
            begin
                if (out_ready)
                begin
                    out_load = 1'b1;
                    if (count_reg == '0)
                    begin
                        out_word.last      = 1'b1;
                        out_word.empty_res = 1'b1;
                        out_word.rejected  = rej_reg;
                        state_next         = S_IDLE;
                    end
                    else
                    begin
                        out_word.entry_high = rd_data.high;
                        out_word.entry_low  = rd_data.low;
                        out_word.last       = is_last;
                        out_word.rejected   = rej_reg;
                        rd_idx_next         = rd_idx_reg + CW'(1);
                        if (is_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            acc_valid_reg <= 1'b0;
            rej_reg       <= 1'b0;
            bank_sel_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            pend_reg      <= pend_next;
            acc_valid_reg <= acc_valid_next;
            rej_reg       <= rej_next;
            bank_sel_reg  <= bank_sel_next;
        end
    end

    // Range payload.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        new_reg <= new_next;
    end

    // Bank control: reads follow the next index so that the registered read
    // data always matches the current index; merged ranges go to the other bank.
    assign cmd_stall = state_reg != S_IDLE;
    assign bank_sel  = bank_sel_reg;
    assign wr_bank   = ~bank_sel_reg;
    assign wr_addr   = wr_idx_reg[AW-1:0];
    assign wr_data   = acc_reg;
    assign rd_addr   = rd_idx_next[AW-1:0];

    // The table never holds more ranges than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // Merged output never overtakes the ranges consumed from the old bank.
    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> (wr_idx_reg <= rd_idx_reg))
        else $error("merge write index passed read index");

    // Every completed merge pass swaps the active bank.
    a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |=> (bank_sel_reg != $past(bank_sel_reg)))
        else $error("bank not swapped after merge");

    // An empty-table word is the only and final word of its item.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_word.empty_res) |-> (out_word.last && (count_reg == '0)))
        else $error("empty word not final or table not empty");

endmodule

>>> design/interval_set_union_core.sv
// Interval union table: holds up to TABLE_DEPTH closed ranges ordered by
// descending high bound. An insert word places its range after all stored
// ranges with an equal or higher high bound and merges overlapping neighbors
// (the merged range keeps the upper high bound and the smaller low bound); a
// clear word empties the table. After every command word the whole table is
// returned, one result word per range, top first, with last on the final word;
// an empty table returns a single word with empty_res set and zero bounds.
// Inserts with high below low, or into a full table, leave the table unchanged
// and set rejected on every result word. One command is handled at a time and
// cmd_stall stays high until its last result word has been loaded into the
// output register. An accepted insert makes one merge step per stored range
// plus one for the new range through a single shared compare unit, then
// returns one result per cycle, while the result side does not stall, read
// back from the table banks. Clear and rejected inserts go straight to
// returning their result words.
module interval_set_union_core
    import isu_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res
);

    logic          out_ready;
    logic          out_load;
    res_word_t     out_word;
    logic          bank_sel;
    logic          wr_en;
    logic          wr_bank;
    logic [AW-1:0] wr_addr;
    range_t        wr_data;
    logic [AW-1:0] rd_addr;
    range_t        rd_data0;
    range_t        rd_data1;
    range_t        rd_data;
    logic          res_valid_reg;
    res_word_t     res_reg;

    // Sequencer with the shared compare unit.
    isu_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_stall (cmd_stall),
        .rd_data   (rd_data),
        .out_ready (out_ready),
        .out_load  (out_load),
        .out_word  (out_word),
        .bank_sel  (bank_sel),
        .wr_en     (wr_en),
        .wr_bank   (wr_bank),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr)
    );

    // Ping-pong table banks: one holds the current table, the other takes the
    // result of the next merge pass.
    isu_bank #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_bank0 (
        .clk     (clk),
        .wr_en   (wr_en && (wr_bank == 1'b0)),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data0)
    );

    isu_bank #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_bank1 (
        .clk     (clk),
        .wr_en   (wr_en && (wr_bank == 1'b1)),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data1)
    );

    assign rd_data = bank_sel ? rd_data1 : rd_data0;

    // Output register: loads when empty or when its word is being taken.
    assign out_ready = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg <= out_word;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> sim/interval_set_union_core_tb.sv
`timescale 1ns / 1ps

module interval_set_union_core_tb
    import isu_pkg::*;
();

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 64;
    localparam int MAX_REPORTS  = 200;

    typedef enum int {STYLE_SPARSE, STYLE_CLUSTER, STYLE_WILD} insert_style_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    typedef struct {
        cmd_word_t cmd;
        bit        typed;
        res_word_t want;
    } plan_row_t;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_word_t cmd;
    logic      res_valid;
    logic      res_stall;
    res_word_t res;

    // Range table as the block should hold it.
    bound_t    tbl_high [DEPTH];
    bound_t    tbl_low  [DEPTH];
    int        tbl_count = 0;

    res_word_t dump_words[$];
    res_word_t awaited_words[$];
    plan_row_t plan[$];

    bit hold_request  = 1'b0;
    int burst_left    = 0;
    int fail_count    = 0;
    int cmds_sent     = 0;
    int words_checked = 0;
    int rejects_sent  = 0;
    int full_hits     = 0;
    int peak_count    = 0;

    interval_set_union_core #(.TABLE_DEPTH(DEPTH)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Apply one command to the table and build the words it should stream out.
    task automatic update_range_table(input cmd_word_t w);
        int        pos;
        int        n;
        logic      rej;
        res_word_t r;
        rej = 1'b0;
        dump_words.delete();
        if (w.op == OP_CLEAR)
        begin
            tbl_count = 0;
        end
        else if (w.range_high < w.range_low || tbl_count >= DEPTH)
        begin
            rej = 1'b1;
            if (tbl_count >= DEPTH)
                full_hits++;
        end
        else
        begin
            // The new range goes below every stored range with an equal or higher top.
            pos = 0;
            while (pos < tbl_count && tbl_high[pos] >= w.range_high)
                pos++;
            for (n = tbl_count; n > pos; n--)
            begin
                tbl_high[n] = tbl_high[n - 1];
                tbl_low[n]  = tbl_low[n - 1];
            end
            tbl_high[pos] = w.range_high;
            tbl_low[pos]  = w.range_low;
            tbl_count++;
            // Walk down from the top and fold each overlapping neighbor into the one above.
            n = 0;
            while (n + 1 < tbl_count)
            begin
                if (tbl_low[n] <= tbl_high[n + 1])
                begin
                    if (tbl_low[n + 1] < tbl_low[n])
                        tbl_low[n] = tbl_low[n + 1];
                    for (pos = n + 1; pos + 1 < tbl_count; pos++)
                    begin
                        tbl_high[pos] = tbl_high[pos + 1];
                        tbl_low[pos]  = tbl_low[pos + 1];
                    end
                    tbl_count--;
                end
                else
                begin
                    n++;
                end
            end
        end
        if (rej)
            rejects_sent++;
        if (tbl_count > peak_count)
            peak_count = tbl_count;

        // An empty table still answers with one word.
        if (tbl_count == 0)
        begin
            r = '0;
            r.last      = 1'b1;
            r.empty_res = 1'b1;
            r.rejected  = rej;
            dump_words.push_back(r);
        end
        else
        begin
            for (n = 0; n < tbl_count; n++)
            begin
                r.entry_high = tbl_high[n];
                r.entry_low  = tbl_low[n];
                r.last       = (n == tbl_count - 1);
                r.empty_res  = 1'b0;
                r.rejected   = rej;
                dump_words.push_back(r);
            end
        end
    endtask

    task automatic plan_cmd(input logic op, input bound_t hi, input bound_t lo);
        plan_row_t row;
        row.cmd.op         = op;
        row.cmd.range_high = hi;
        row.cmd.range_low  = lo;
        row.typed          = 1'b0;
        row.want           = '0;
        plan.push_back(row);
    endtask

    // A row whose answer is a single word written out by hand.
    task automatic plan_single(input logic op, input bound_t hi, input bound_t lo,
                               input bound_t w_hi, input bound_t w_lo,
                               input logic w_empty, input logic w_rej);
        plan_row_t row;
        row.cmd.op          = op;
        row.cmd.range_high  = hi;
        row.cmd.range_low   = lo;
        row.typed           = 1'b1;
        row.want.entry_high = w_hi;
        row.want.entry_low  = w_lo;
        row.want.last       = 1'b1;
        row.want.empty_res  = w_empty;
        row.want.rejected   = w_rej;
        plan.push_back(row);
    endtask

    // Offer one command word in bursts with random gaps, and record what it should return.
    task automatic send_word(input cmd_word_t w, input bit typed, input res_word_t want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
            end
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= w;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
        burst_left--;
        cmds_sent++;
        update_range_table(w);
        if (typed)
            awaited_words.push_back(want);
        else
            foreach (dump_words[i])
                awaited_words.push_back(dump_words[i]);
    endtask

    task automatic drain_results();
        @(negedge clk);
        cmd_valid <= 1'b0;
        burst_left = 0;
        while (awaited_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic cmd_word_t random_insert(input insert_style_t style, input int base);
        cmd_word_t w;
        int        lo;
        int        hi;
        int        tmp;
        case (style)
            STYLE_SPARSE:
            begin
                lo = $urandom_range(0, 65535);
                hi = lo + $urandom_range(0, 255);
            end
            STYLE_CLUSTER:
            begin
                lo = base + $urandom_range(0, 767);
                hi = lo + $urandom_range(0, 48);
            end
            default:
            begin
                lo = $urandom_range(0, 65535);
                hi = $urandom_range(0, 65535);
                if (hi < lo && $urandom_range(0, 4) != 0)
                begin
                    tmp = hi;
                    hi  = lo;
                    lo  = tmp;
                end
            end
        endcase
        if (hi > 65535)
            hi = 65535;
        if (lo > 65535)
            lo = 65535;
        w.op         = OP_INSERT;
        w.range_high = bound_t'(hi);
        w.range_low  = bound_t'(lo);
        return w;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Compare every result word taken from the block with the oldest one awaited.
    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (awaited_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result word, expected none, got %p", $time, res);
            end
            else
            begin
                want = awaited_words.pop_front();
                words_checked++;
                check_field("entry_high", want.entry_high, res.entry_high);
                check_field("entry_low", want.entry_low, res.entry_low);
                check_field("last", 16'(want.last), 16'(res.last));
                check_field("empty_res", 16'(want.empty_res), 16'(res.empty_res));
                check_field("rejected", 16'(want.rejected), 16'(res.rejected));
            end
        end
    end

    // Result side stall: changing patterns, plus one long hold-off on request.
    initial
    begin
        stall_mode_t mode;
        int          pattern_left;
        res_stall    = 1'b0;
        mode         = STALL_NONE;
        pattern_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    mode         = stall_mode_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                case (mode)
                    STALL_NONE:  res_stall <= 1'b0;
                    STALL_LIGHT: res_stall <= ($urandom_range(0, 99) < 30);
                    STALL_HEAVY: res_stall <= ($urandom_range(0, 99) < 75);
                    default:     res_stall <= ((pattern_left % 4) != 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid === 1'b1 && cmd_stall === 1'b0) ||
                (res_valid === 1'b1 && res_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus: directed rows, a fill to capacity, then random episodes.
    initial
    begin
        cmd_word_t     w;
        res_word_t     none;
        insert_style_t style;
        int            base;
        int            len;
        int            k;
        int            random_sent;
        bit            hold_done;
        bit            pause_done;

        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd         = '0;
        none        = '0;
        random_sent = 0;
        hold_done   = 1'b0;
        pause_done  = 1'b0;

        // Edge cases: empty table, rejects, extreme bounds, equal tops, touching ranges.
        plan_single(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
        plan_single(OP_INSERT, 16'h0005, 16'h0009, 16'h0000, 16'h0000, 1'b1, 1'b1);
        plan_single(OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        plan_cmd(OP_INSERT, 16'hFFFF, 16'hFFFF);
        plan_cmd(OP_INSERT, 16'h8000, 16'h7FFF);
        plan_cmd(OP_INSERT, 16'h7FFF, 16'h0001);
        plan_cmd(OP_INSERT, 16'h0001, 16'h0001);
        plan_cmd(OP_INSERT, 16'hFFFF, 16'h0000);
        plan_cmd(OP_INSERT, 16'hFFFF, 16'hFFFF);
        plan_cmd(OP_INSERT, 16'h0001, 16'h0002);
        plan_single(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
        plan_single(OP_INSERT, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
        plan_single(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
        plan_single(OP_INSERT, 16'h0100, 16'h0090, 16'h0100, 16'h0090, 1'b0, 1'b0);
        plan_cmd(OP_INSERT, 16'h0100, 16'h0095);
        plan_cmd(OP_INSERT, 16'h008F, 16'h0080);
        plan_cmd(OP_INSERT, 16'h0090, 16'h0085);
        plan_cmd(OP_INSERT, 16'h5555, 16'hAAAA);
        plan_cmd(OP_INSERT, 16'hAAAA, 16'h5555);
        plan_single(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 1'b0);

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
            send_word(plan[i].cmd, plan[i].typed, plan[i].want);

        // Fill the table with disjoint ranges, each landing on top, then knock on a full table.
        for (k = 0; k < DEPTH; k++)
        begin
            w.op         = OP_INSERT;
            w.range_low  = bound_t'(k * 4096 + 16);
            w.range_high = bound_t'(k * 4096 + 24);
            send_word(w, 1'b0, none);
        end
        w.op         = OP_INSERT;
        w.range_high = 16'hFFFF;
        w.range_low  = 16'h0000;
        send_word(w, 1'b0, none);
        w.range_high = 16'h0000;
        w.range_low  = 16'hFFFF;
        send_word(w, 1'b0, none);

        // Random episodes: mostly a clear followed by a run of inserts of one style.
        while (random_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                w = '0;
                w.op = OP_CLEAR;
                send_word(w, 1'b0, none);
                random_sent++;
            end
            style = insert_style_t'($urandom_range(0, 2));
            base  = $urandom_range(0, 64700);
            len   = $urandom_range(1, 24);
            repeat (len)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    w.op         = 1'($urandom_range(0, 1));
                    w.range_high = bound_t'($urandom_range(0, 65535));
                    w.range_low  = bound_t'($urandom_range(0, 65535));
                end
                else
                begin
                    w = random_insert(style, base);
                end
                send_word(w, 1'b0, none);
                random_sent++;
                if (!hold_done && random_sent >= 120)
                begin
                    hold_done    = 1'b1;
                    hold_request = 1'b1;
                end
                if (!pause_done && random_sent >= 260)
                begin
                    pause_done = 1'b1;
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Sent %0d command words; %0d inserts were rejected, %0d of them on a full table.",
                 cmds_sent, rejects_sent, full_hits);
        $display("Checked %0d result words; the table held up to %0d ranges.",
                 words_checked, peak_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
